>>> hdl/jss_pkg.sv
// Shared constants, types and state codes of the sparse Jacobi sweep block.
package jss_pkg;

  localparam int unsigned MAX_ROWS  = 1024;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned ADDR_W = $clog2(MAX_ROWS);
  localparam int unsigned ROWS_W = $clog2(MAX_ROWS) + 1;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_NONZERO = 1'b1;

  localparam logic [WORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_NUM  = 8'b0000_1000,
    S_ABS  = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } seq_state_e;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

endpackage

>>> hdl/jacobi_sparse_sweep.sv
// Top level of the sparse Jacobi sweep: solution store, multiply-accumulate and row sequencer.
//
//   Channel   Signals                                          Handshake
//   --------  -----------------------------------------------  -------------------------------
//   command   cmd_i row_index_i col_index_i item_value_i       taken when start_i && !busy_o
//             rhs_value_i row_end_i
//   result    out_row_o new_value_o diag_error_o saturated_o   valid for one cycle on done_o
//
// A load item, and a diagonal item that does not end its row, leave the block idle. An
// off-diagonal item holds it busy through a multiply and an accumulate state.
// A row end adds busy states for the subtract, absolute value and compare, the 32-step
// divide and the result; an oversized quotient skips the divide and a missing or zero
// diagonal adds only the subtract. Reset clears the sequencer and the row state, not the
// store, which must be loaded first. The receiver cannot stall a result.
module jacobi_sparse_sweep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              cmd_i,
  input  logic        [jss_pkg::IDX_W-1:0]  row_index_i,
  input  logic        [jss_pkg::IDX_W-1:0]  col_index_i,
  input  logic signed [jss_pkg::WORD_W-1:0] item_value_i,
  input  logic signed [jss_pkg::WORD_W-1:0] rhs_value_i,
  input  logic                              row_end_i,
  output logic                              done_o,
  output logic        [jss_pkg::IDX_W-1:0]  out_row_o,
  output logic signed [jss_pkg::WORD_W-1:0] new_value_o,
  output logic                              diag_error_o,
  output logic                              saturated_o
);
  import jss_pkg::*;

  localparam logic [ROWS_W-1:0] RowsLimit = ROWS_W'(MAX_ROWS);
  localparam int unsigned       HiShift   = WORD_W - FRAC_BITS;

  seq_state_e state_q, state_d;

  logic              accept;
  logic              col_ok;
  logic              is_diag;
  logic [ADDR_W-1:0] mem_addr;

  // Captured item fields.
  logic        [IDX_W-1:0]  row_q;
  logic signed [WORD_W-1:0] val_q;
  logic signed [WORD_W-1:0] rhs_q;
  logic                     end_q;
  logic                     col_ok_q;

  // Old solution store with a registered read port.
  logic [WORD_W-1:0] sol_mem [MAX_ROWS];
  logic [WORD_W-1:0] sol_rd_q;

  // Row state.
  logic [ACC_W-1:0]  sum_q;
  logic [WORD_W-1:0] diag_q;
  logic              seen_q;
  logic              diag_bad;

  // Datapath registers.
  logic signed [ACC_W-1:0]  val_x;
  logic signed [ACC_W-1:0]  op_x;
  logic signed [ACC_W-1:0]  prod_q;
  logic        [ACC_W-1:0]  prod_sh;
  logic        [ACC_W-1:0]  num_q;
  logic        [ACC_W-1:0]  mag_q;
  logic        [ACC_W-1:0]  mag_hi;
  logic        [WORD_W-1:0] dm_q;
  logic                     neg_q;
  logic                     big_q;
  logic                     big_now;

  // Divider interface and result shaping.
  div_req_t          div_req;
  logic [WORD_W-1:0] quot;
  logic              div_done;
  logic              fin_sat;
  logic [WORD_W-1:0] fin_value;

  // Result registers.
  logic                     done_q;
  logic        [IDX_W-1:0]  out_row_q;
  logic signed [WORD_W-1:0] new_value_q;
  logic                     diag_error_q;
  logic                     saturated_q;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign col_ok   = ROWS_W'(col_index_i) < RowsLimit;
  assign is_diag  = (col_index_i == row_index_i);
  assign mem_addr = ADDR_W'(col_index_i);
  assign diag_bad = !seen_q || (diag_q == '0);

  always_ff @(posedge clk_i) begin
    if (accept && (cmd_i == CMD_LOAD) && col_ok) begin
      sol_mem[mem_addr] <= item_value_i;
    end
    if (accept && (cmd_i == CMD_NONZERO)) begin
      sol_rd_q <= sol_mem[mem_addr];
    end
  end

  // Sequencer: one item at a time, the single divider serves every row finish that needs it.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_NONZERO)) begin
          if (!is_diag) begin
            state_d = S_MUL;
          end else if (row_end_i) begin
            state_d = S_NUM;
          end
        end
      end
      S_MUL: state_d = S_ACC;
      S_ACC: state_d = end_q ? S_NUM : S_IDLE;
      S_NUM: state_d = diag_bad ? S_IDLE : S_ABS;
      S_ABS: state_d = S_CHK;
      S_CHK: state_d = big_now ? S_FIN : S_DIV;
      S_DIV: state_d = div_done ? S_FIN : S_DIV;
      S_FIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q    <= row_index_i;
      val_q    <= item_value_i;
      rhs_q    <= rhs_value_i;
      end_q    <= row_end_i;
      col_ok_q <= col_ok;
    end
  end

  // Product of the matrix value and the old solution entry; a column past the store reads zero.
  always_comb begin
    val_x = {{(ACC_W-WORD_W){val_q[WORD_W-1]}}, val_q};
    op_x  = col_ok_q ? {{(ACC_W-WORD_W){sol_rd_q[WORD_W-1]}}, sol_rd_q} : '0;
  end

  // The product is brought back to Q16.16 with rounding toward minus infinity.
  assign prod_sh = prod_q >>> FRAC_BITS;

  assign mag_hi  = mag_q >> HiShift;
  assign big_now = mag_hi >= {{(ACC_W-WORD_W){1'b0}}, dm_q};

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_MUL: prod_q <= val_x * op_x;
      S_NUM: num_q <= {{(ACC_W-WORD_W){rhs_q[WORD_W-1]}}, rhs_q} - sum_q;
      S_ABS: begin
        mag_q <= num_q[ACC_W-1] ? (~num_q + 1'b1) : num_q;
        dm_q  <= diag_q[WORD_W-1] ? (~diag_q + 1'b1) : diag_q;
        neg_q <= num_q[ACC_W-1] ^ diag_q[WORD_W-1];
      end
      S_CHK: big_q <= big_now;
      default: ;
    endcase
  end

  // Row accumulator and diagonal capture; cleared when the row's result goes out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      diag_q <= '0;
      seen_q <= 1'b0;
    end else if (state_q == S_FIN || (state_q == S_NUM && diag_bad)) begin
      sum_q  <= '0;
      diag_q <= '0;
      seen_q <= 1'b0;
    end else if (state_q == S_ACC) begin
      sum_q <= sum_q + prod_sh;
    end else if (accept && (cmd_i == CMD_NONZERO) && is_diag) begin
      diag_q <= item_value_i;
      seen_q <= 1'b1;
    end
  end

  // The upper quotient bits are settled by the compare, so the divider only runs 32 steps.
  always_comb begin
    div_req.start   = (state_q == S_CHK) && !big_now;
    div_req.rem     = mag_hi[WORD_W-1:0];
    div_req.low     = {mag_q[HiShift-1:0], {FRAC_BITS{1'b0}}};
    div_req.divisor = dm_q;
  end

  jss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .quot_o (quot),
    .done_o (div_done)
  );

  always_comb begin
    fin_sat = big_q || (neg_q ? (quot > NEG_LIMIT) : quot[WORD_W-1]);
    if (fin_sat) begin
      fin_value = neg_q ? NEG_LIMIT : POS_LIMIT;
    end else begin
      fin_value = neg_q ? (~quot + 1'b1) : quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_FIN) || (state_q == S_NUM && diag_bad);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_NUM && diag_bad) begin
      out_row_q    <= row_q;
      new_value_q  <= '0;
      diag_error_q <= 1'b1;
      saturated_q  <= 1'b0;
    end else if (state_q == S_FIN) begin
      out_row_q    <= row_q;
      new_value_q  <= fin_value;
      diag_error_q <= 1'b0;
      saturated_q  <= fin_sat;
    end
  end

  assign done_o       = done_q;
  assign out_row_o    = out_row_q;
  assign new_value_o  = new_value_q;
  assign diag_error_o = diag_error_q;
  assign saturated_o  = saturated_q;

`ifndef SYNTH
  // A result only ever follows a cycle in which the sequencer was working on a row end.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy_o))
    else $error("result strobe without preceding work");

  // A load item never makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CMD_LOAD)) |=> !busy_o)
    else $error("load item held the block busy");

  // An error result carries a zero value and no clipping flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && diag_error_o) |-> (new_value_o == '0) && !saturated_o)
    else $error("error result with nonzero payload");

  // A clipped result sits at one of the two range limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (new_value_o == POS_LIMIT) || (new_value_o == NEG_LIMIT))
    else $error("saturated result not at a limit");
`endif

endmodule

>>> hdl/jss_div.sv
// Restoring divider that produces one quotient bit per cycle.
module jss_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jss_pkg::div_req_t          req_i,
  output logic [jss_pkg::WORD_W-1:0] quot_o,
  output logic                       done_o
);
  import jss_pkg::*;

  localparam logic [CNT_W-1:0] LastStep = CNT_W'(WORD_W - 1);

  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] low_q, low_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q;
  logic              done_q;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              take;

  // The partial remainder always stays below the divisor, so one extra bit suffices.
  always_comb begin
    trial = {rem_q, low_q[WORD_W-1]};
    diff  = trial - {1'b0, req_i.divisor};
    take  = trial >= {1'b0, req_i.divisor};
    rem_d = take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    low_d = {low_q[WORD_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      low_q <= req_i.low;
    end else if (run_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign quot_o = low_q;
  assign done_o = done_q;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sparse Jacobi sweep: directed rows, then random rows.
`timescale 1ns / 1ps

module testbench;
  import jss_pkg::*;

  // At least 540 items in all; the random rows stop once this count is reached.
  localparam int unsigned ITEM_TARGET = 540;
  // Cycles with neither an accepted item nor a result before the run is abandoned. The
  // slowest correct gap is a full row finish plus the longest idle stretch on the command
  // side, so this is many times that.
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles to keep watching for stray results once nothing is pending.
  localparam int unsigned DRAIN_CYCLES = 60;

  localparam logic signed [95:0] QUOT_MAX = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] QUOT_MIN = -96'sh8000_0000;

  // One new solution entry as the block reports it.
  typedef struct {
    logic [IDX_W-1:0]         row;
    logic signed [WORD_W-1:0] value;
    logic                     err;
    logic                     sat;
  } row_result_t;

  // One command item. A pinned item carries a result typed in by hand, which is used in
  // place of the predicted one.
  typedef struct {
    logic                     cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [WORD_W-1:0] val;
    logic signed [WORD_W-1:0] rhs;
    logic                     last;
    bit                       pinned;
    row_result_t              pinned_res;
  } sweep_item_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic                     cmd_i;
  logic [IDX_W-1:0]         row_index_i;
  logic [IDX_W-1:0]         col_index_i;
  logic signed [WORD_W-1:0] item_value_i;
  logic signed [WORD_W-1:0] rhs_value_i;
  logic                     row_end_i;
  logic                     done_o;
  logic [IDX_W-1:0]         out_row_o;
  logic signed [WORD_W-1:0] new_value_o;
  logic                     diag_error_o;
  logic                     saturated_o;

  // The item currently on the command ports, so the monitor can see a pinned result.
  sweep_item_t shown_item;

  // Predictor state: the old solution store and the running row.
  logic signed [WORD_W-1:0] sol_store [MAX_ROWS];
  logic [ACC_W-1:0]         acc_sum    = '0;
  logic signed [WORD_W-1:0] diag_word  = '0;
  bit                       diag_found = 1'b0;

  row_result_t      pending_rows [$];
  logic [IDX_W-1:0] loaded_cols [$];
  int unsigned      mismatch_count = 0;
  int unsigned      items_sent     = 0;
  int unsigned      stall_cycles   = 0;

  jacobi_sparse_sweep dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .item_value_i (item_value_i),
    .rhs_value_i  (rhs_value_i),
    .row_end_i    (row_end_i),
    .done_o       (done_o),
    .out_row_o    (out_row_o),
    .new_value_o  (new_value_o),
    .diag_error_o (diag_error_o),
    .saturated_o  (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Works out what one accepted item does to the sweep. Loads write the store. An
  // off-diagonal nonzero adds value * old solution, floor-shifted back to Q16.16, to the
  // row sum; a diagonal nonzero is captured, the last one of the row winning. On a row
  // end with a usable diagonal the quotient (rhs - sum) / diagonal is formed exactly in a
  // wide signed divide, truncated toward zero and clipped to 32 bits. Returns 1 when a result is due.
  function automatic bit jacobi_update(input sweep_item_t it, output row_result_t res);
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] numer;
    logic signed [95:0]      wide_num;
    logic signed [95:0]      wide_den;
    logic signed [95:0]      quot;
    res = '{row: '0, value: '0, err: 1'b0, sat: 1'b0};
    if (it.cmd == CMD_LOAD) begin
      sol_store[it.col] = it.val;
      return 1'b0;
    end
    if (it.col == it.row) begin
      diag_word  = it.val;
      diag_found = 1'b1;
    end else begin
      prod = $signed({{32{it.val[31]}}, it.val}) *
             $signed({{32{sol_store[it.col][31]}}, sol_store[it.col]});
      prod    = prod >>> FRAC_BITS;
      acc_sum = acc_sum + prod;
    end
    if (!it.last) return 1'b0;
    res.row = it.row;
    if (!diag_found || diag_word == '0) begin
      // Missing or zero diagonal: value stays 0 and only the error flag is raised.
      res.err = 1'b1;
    end else begin
      numer    = {{32{it.rhs[31]}}, it.rhs} - acc_sum;
      wide_num = {{32{numer[63]}}, numer};
      wide_num = wide_num <<< FRAC_BITS;
      wide_den = {{64{diag_word[31]}}, diag_word};
      quot     = wide_num / wide_den;
      if (quot > QUOT_MAX) begin
        res.value = POS_LIMIT;
        res.sat   = 1'b1;
      end else if (quot < QUOT_MIN) begin
        res.value = NEG_LIMIT;
        res.sat   = 1'b1;
      end else begin
        res.value = quot[WORD_W-1:0];
      end
    end
    acc_sum    = '0;
    diag_word  = '0;
    diag_found = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Monitor and scoreboard. Everything is sampled at the rising edge, so the values seen
  // are the ones held through the cycle that this edge ends. A result is checked before
  // the item taken at the same edge is predicted; that item cannot have caused it.
  always @(posedge clk_i) begin : monitor
    row_result_t got;
    row_result_t want;
    row_result_t pred;
    sweep_item_t took;
    if (rst_ni) begin
      if (done_o) begin
        got = '{row: out_row_o, value: new_value_o, err: diag_error_o, sat: saturated_o};
        if (pending_rows.size() == 0) begin
          report_mismatch($sformatf("result for row %0d with no row pending", got.row));
        end else begin
          want = pending_rows.pop_front();
          if (got.row !== want.row || got.value !== want.value ||
              got.err !== want.err || got.sat !== want.sat)
            report_mismatch($sformatf(
              "row %0d value %h err %b sat %b, predicted row %0d value %h err %b sat %b",
              got.row, got.value, got.err, got.sat,
              want.row, want.value, want.err, want.sat));
        end
      end
      if (start_i && !busy_o) begin
        took        = shown_item;
        took.cmd    = cmd_i;
        took.row    = row_index_i;
        took.col    = col_index_i;
        took.val    = item_value_i;
        took.rhs    = rhs_value_i;
        took.last   = row_end_i;
        if (jacobi_update(took, pred))
          pending_rows.push_back(took.pinned ? took.pinned_res : pred);
      end
    end
  end

  // Watchdog: the run is abandoned when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item accepted and no result for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic sweep_item_t ld(input logic [IDX_W-1:0] c, input logic [WORD_W-1:0] v,
                                     input logic [IDX_W-1:0] r, input logic e);
    sweep_item_t it;
    it = '{cmd: CMD_LOAD, row: r, col: c, val: v, rhs: $urandom(), last: e, pinned: 1'b0,
           pinned_res: '{row: '0, value: '0, err: 1'b0, sat: 1'b0}};
    return it;
  endfunction

  function automatic sweep_item_t nz(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                     input logic [WORD_W-1:0] v, input logic [WORD_W-1:0] h,
                                     input logic e);
    sweep_item_t it;
    it = '{cmd: CMD_NONZERO, row: r, col: c, val: v, rhs: h, last: e, pinned: 1'b0,
           pinned_res: '{row: '0, value: '0, err: 1'b0, sat: 1'b0}};
    return it;
  endfunction

  function automatic sweep_item_t pin(input sweep_item_t it, input logic [IDX_W-1:0] r,
                                      input logic [WORD_W-1:0] v, input logic e,
                                      input logic s);
    it.pinned     = 1'b1;
    it.pinned_res = '{row: r, value: v, err: e, sat: s};
    return it;
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    return IDX_W'($urandom_range(0, MAX_ROWS - 1));
  endfunction

  // Mostly modest Q16.16 values so quotients stay in range, with full-range words and
  // the extremes mixed in.
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
    endcase
  endfunction

  // Diagonals: usually a moderate magnitude of either sign, sometimes zero, one ulp or
  // a full-range word.
  function automatic logic [WORD_W-1:0] rand_diag();
    logic [WORD_W-1:0] mag;
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 32'h0000_0001;
      2: return $urandom();
      default: begin
        mag = $urandom_range(32'h0000_4000, 32'h0004_0000);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  // A column other than r whose store entry has been written.
  function automatic logic [IDX_W-1:0] pick_col(input logic [IDX_W-1:0] r);
    logic [IDX_W-1:0] c;
    do c = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]; while (c == r);
    return c;
  endfunction

  // Presents one item and returns at the edge that accepts it. Start stays high from one
  // item to the next unless an idle stretch is drawn; a stretch is usually short but now
  // and then long enough to span a whole row finish. The middle of the run never idles.
  task automatic send(input sweep_item_t it);
    bit idle_ok;
    idle_ok = !(items_sent >= 250 && items_sent < 400);
    if (idle_ok && $urandom_range(0, 99) < 6) begin
      start_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 40)) @(posedge clk_i);
      else repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    cmd_i        <= it.cmd;
    row_index_i  <= it.row;
    col_index_i  <= it.col;
    item_value_i <= it.val;
    rhs_value_i  <= it.rhs;
    row_end_i    <= it.last;
    shown_item   <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (it.cmd == CMD_LOAD) loaded_cols.push_back(it.col);
    items_sent++;
  endtask

  // One random row. Most rows are well formed: a few loads, then one to six nonzeros
  // with one diagonal and the row end on the last. Off-diagonal columns are either
  // already loaded or loaded just before use, inside the row. The rest are broken rows:
  // no diagonal, an extra diagonal, or a stray item from another row.
  task automatic send_row();
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] q;
    logic [IDX_W-1:0] c;
    int               n;
    int               diag_pos;
    int               shape;
    bit               ends;
    r     = rand_index();
    shape = ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 3);
    repeat ($urandom_range(0, 3))
      send(ld(rand_index(), rand_word(), rand_index(), 1'($urandom_range(0, 1))));
    n        = $urandom_range(1, 6);
    diag_pos = (shape == 1) ? -1 : $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      ends = (k == n - 1);
      if (k == 0 && shape == 2) send(nz(r, r, rand_diag(), $urandom(), 1'b0));
      if (k == 0 && shape == 3) begin
        q = rand_index();
        if ($urandom_range(0, 1)) send(nz(q, q, rand_diag(), $urandom(), 1'b0));
        else send(nz(q, pick_col(q), rand_word(), $urandom(), 1'b0));
      end
      if (k == diag_pos) begin
        send(nz(r, r, rand_diag(), rand_word(), ends));
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          do c = rand_index(); while (c == r);
          send(ld(c, rand_word(), rand_index(), 1'($urandom_range(0, 1))));
        end else begin
          c = pick_col(r);
        end
        send(nz(r, c, rand_word(), rand_word(), ends));
      end
    end
  endtask

  initial begin : stimulus
    sweep_item_t directed_tbl [$];
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    cmd_i        <= CMD_LOAD;
    row_index_i  <= '0;
    col_index_i  <= '0;
    item_value_i <= '0;
    rhs_value_i  <= '0;
    row_end_i    <= 1'b0;
    shown_item   <= ld('0, '0, '0, 1'b0);

    // Directed rows. Pinned rows can be read off by eye; the rest go to the predictor.
    // A lone diagonal of 1.0 right after reset returns the right-hand side.
    directed_tbl.push_back(pin(nz(10'd5, 10'd5, 32'h0001_0000, 32'h0003_0000, 1'b1),
                               10'd5, 32'h0003_0000, 1'b0, 1'b0));
    // Store entries at both ends of the index range and with extreme values.
    directed_tbl.push_back(ld(10'd0, 32'h7FFF_FFFF, 10'd0, 1'b0));
    directed_tbl.push_back(ld(10'd1023, 32'h8000_0000, 10'd0, 1'b0));
    directed_tbl.push_back(ld(10'd1, 32'h0001_0000, 10'd0, 1'b0));
    directed_tbl.push_back(ld(10'd2, 32'hFFFF_0000, 10'd0, 1'b0));
    // An ordinary row whose diagonal item also ends it.
    directed_tbl.push_back(nz(10'd0, 10'd1, 32'h0002_0000, 32'hFFFF_FFFF, 1'b0));
    directed_tbl.push_back(nz(10'd0, 10'd0, 32'h0001_0000, 32'h0005_0000, 1'b1));
    // A row without a diagonal, then a row whose diagonal is zero.
    directed_tbl.push_back(pin(nz(10'd3, 10'd2, 32'h0001_0000, 32'h0000_0000, 1'b1),
                               10'd3, 32'h0, 1'b1, 1'b0));
    directed_tbl.push_back(pin(nz(10'd4, 10'd4, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1),
                               10'd4, 32'h0, 1'b1, 1'b0));
    // Tiny diagonal with extreme right-hand sides: clipped at both limits.
    directed_tbl.push_back(pin(nz(10'd6, 10'd6, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1),
                               10'd6, POS_LIMIT, 1'b0, 1'b1));
    directed_tbl.push_back(pin(nz(10'd8, 10'd8, 32'h0000_0001, 32'h8000_0000, 1'b1),
                               10'd8, NEG_LIMIT, 1'b0, 1'b1));
    // Largest products of both signs into the accumulator, most negative diagonal.
    directed_tbl.push_back(nz(10'd1022, 10'd0, 32'h8000_0000, 32'h0000_0000, 1'b0));
    directed_tbl.push_back(nz(10'd1022, 10'd1023, 32'h8000_0000, 32'h0000_0000, 1'b0));
    directed_tbl.push_back(nz(10'd1022, 10'd1022, 32'h8000_0000, 32'h8000_0000, 1'b1));
    // Two diagonals in one row: the later one counts.
    directed_tbl.push_back(nz(10'd9, 10'd9, 32'h0000_0000, 32'h0000_0000, 1'b0));
    directed_tbl.push_back(pin(nz(10'd9, 10'd9, 32'h0002_0000, 32'h0004_0000, 1'b1),
                               10'd9, 32'h0002_0000, 1'b0, 1'b0));
    // Items of two rows mixed: the sum carries over and the row end names the row.
    directed_tbl.push_back(nz(10'd10, 10'd1, 32'h0001_0000, 32'h0000_0000, 1'b0));
    directed_tbl.push_back(nz(10'd11, 10'd11, 32'h0001_0000, 32'h0000_0000, 1'b1));
    // A load inside a row, with its ignored fields set, takes effect at once.
    directed_tbl.push_back(nz(10'd12, 10'd2, 32'h0001_0000, 32'h0000_0000, 1'b0));
    directed_tbl.push_back(ld(10'd2, 32'h0003_0000, 10'd1023, 1'b1));
    directed_tbl.push_back(nz(10'd12, 10'd2, 32'h0001_0000, 32'h0000_0000, 1'b0));
    directed_tbl.push_back(nz(10'd12, 10'd12, 32'h0001_0000, 32'h0000_0000, 1'b1));
    // Highest row index.
    directed_tbl.push_back(nz(10'd1023, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    directed_tbl.push_back(nz(10'd1023, 10'd1023, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) send(directed_tbl[i]);
    while (items_sent < ITEM_TARGET) send_row();
    start_i <= 1'b0;

    // Let the last rows finish, then keep watching for anything extra.
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
